FILE: rtl/icmp_echo_parser_top_macros.svh
// assertion macros shared by the icmp echo parser rtl
`ifndef ICMP_ECHO_PARSER_TOP_MACROS_SVH
`define ICMP_ECHO_PARSER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define IEP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iep assertion failed");

// next-cycle implication
`define IEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iep assertion failed");

`else

`define IEP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/iep_pkg.sv
// types and constants of the icmp echo parser
package iep_pkg;

    localparam logic [15:0] HEADER_LEN        = 16'd8;
    localparam logic [15:0] WORD_ALL          = 16'hFFFF;
    localparam logic [7:0]  TYPE_REQUEST      = 8'd8;
    localparam logic [7:0]  TYPE_REPLY        = 8'd0;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1472;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam int   APB_ADDR_W      = 3;
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_BAD_CODE  = 3'd3,
        ST_BAD_CSUM  = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic        is_request;
        logic [15:0] identifier;
        logic [15:0] sequence_res;
        logic [15:0] checksum_field;
        logic [15:0] body_len;
    } t_result;

    // a = payload result, b = status result; a goes out first
    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } t_push;

endpackage

FILE: rtl/iep_cfg.sv
// apb register block holding the payload length limit
module iep_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iep_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [15:0]                    o_max_body_len
);

    logic [15:0] r_max;
    logic        w_index;
    logic        w_write;

    assign w_index = paddr[iep_pkg::APB_ADDR_W-1];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= iep_pkg::MAX_PAYLOAD_RESET;
        end else if (w_write && (w_index == iep_pkg::REG_MAX_PAYLOAD)) begin
            r_max <= pwdata[15:0];
        end
    end

    always_comb begin
        unique case (w_index)
            iep_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, r_max};
            default:                  prdata = '0;
        endcase
    end

    assign o_max_body_len = r_max;

endmodule

FILE: rtl/iep_core.sv
// input register, header capture, checksum and status decision
`include "icmp_echo_parser_top_macros.svh"

module iep_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [7:0]       i_byte_value,
    input  logic             i_last_byte,
    output logic             o_in_stall,
    input  logic             i_room,
    input  logic [15:0]      i_max_body_len,
    output iep_pkg::t_push   o_push,
    output iep_pkg::t_result o_res_a,
    output iep_pkg::t_result o_res_b
);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    logic [15:0] r_byte_count;
    logic [15:0] r_sum;
    logic [7:0]  r_pending;
    logic [7:0]  r_type;
    logic [7:0]  r_code;
    logic [15:0] r_id;
    logic [15:0] r_seq;
    logic [15:0] r_csum;

    logic [15:0] n_byte_count;
    logic [15:0] n_sum;
    logic [7:0]  n_pending;
    logic [7:0]  n_type;
    logic [7:0]  n_code;
    logic [15:0] n_id;
    logic [15:0] n_seq;
    logic [15:0] n_csum;

    logic        w_fire;
    logic        w_in_header;
    logic        w_add;
    logic [15:0] w_word;
    logic [16:0] w_sum_wide;
    logic [15:0] w_plen;
    logic        w_type_bad;
    logic        w_at_top;
    iep_pkg::t_status w_status;

    assign w_fire     = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_byte_value;
            r_last <= i_last_byte;
        end
    end

    assign w_in_header = (r_byte_count < iep_pkg::HEADER_LEN);
    assign w_at_top    = (r_byte_count == iep_pkg::WORD_ALL);

    // header capture
    always_comb begin
        n_type = r_type;
        n_code = r_code;
        n_csum = r_csum;
        n_id   = r_id;
        n_seq  = r_seq;
        if (w_in_header) begin
            case (r_byte_count[2:0])
                3'd0:         n_type = r_byte;
                3'd1:         n_code = r_byte;
                3'd2, 3'd3:   n_csum = {r_csum[7:0], r_byte};
                3'd4, 3'd5:   n_id   = {r_id[7:0], r_byte};
                default:      n_seq  = {r_seq[7:0], r_byte};
            endcase
        end
    end

    // one's-complement sum, a lone final byte is the high half of a word
    always_comb begin
        if (!r_byte_count[0]) begin
            w_add     = r_last;
            w_word    = {r_byte, 8'h00};
            n_pending = r_last ? r_pending : r_byte;
        end else begin
            w_add     = 1'b1;
            w_word    = {r_pending, r_byte};
            n_pending = r_pending;
        end
        w_sum_wide = {1'b0, r_sum} + {1'b0, w_word};
        n_sum      = w_add ? (w_sum_wide[15:0] + {15'd0, w_sum_wide[16]}) : r_sum;
    end

    // counter sticks at all ones
    assign n_byte_count = w_at_top ? r_byte_count : r_byte_count + 16'd1;
    assign w_plen       = n_byte_count - iep_pkg::HEADER_LEN;
    assign w_type_bad   = (n_type != iep_pkg::TYPE_REQUEST) && (n_type != iep_pkg::TYPE_REPLY);

    always_comb begin
        if (n_byte_count < iep_pkg::HEADER_LEN) begin
            w_status = iep_pkg::ST_SHORT;
        end else if (w_type_bad) begin
            w_status = iep_pkg::ST_BAD_TYPE;
        end else if (n_code != 8'd0) begin
            w_status = iep_pkg::ST_BAD_CODE;
        end else if (n_sum != iep_pkg::WORD_ALL) begin
            w_status = iep_pkg::ST_BAD_CSUM;
        end else if (w_plen > i_max_body_len) begin
            w_status = iep_pkg::ST_TOO_LONG;
        end else begin
            w_status = iep_pkg::ST_OK;
        end
    end

    always_comb begin
        o_res_a              = '0;
        o_res_a.result_kind  = iep_pkg::KIND_PAYLOAD;
        o_res_a.payload_byte = r_byte;
        o_res_a.status       = iep_pkg::ST_OK;

        o_res_b              = '0;
        o_res_b.result_kind  = iep_pkg::KIND_STATUS;
        o_res_b.status       = w_status;
        if (w_status == iep_pkg::ST_OK) begin
            o_res_b.is_request     = (n_type == iep_pkg::TYPE_REQUEST);
            o_res_b.identifier     = n_id;
            o_res_b.sequence_res   = n_seq;
            o_res_b.checksum_field = n_csum;
            o_res_b.body_len       = w_plen;
        end

        o_push.a_valid = w_fire && !w_in_header;
        o_push.b_valid = w_fire && r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_sum        <= '0;
            r_pending    <= '0;
            r_type       <= '0;
            r_code       <= '0;
            r_id         <= '0;
            r_seq        <= '0;
            r_csum       <= '0;
        end else if (w_fire) begin
            if (r_last) begin
                r_byte_count <= '0;
                r_sum        <= '0;
                r_pending    <= '0;
                r_type       <= '0;
                r_code       <= '0;
                r_id         <= '0;
                r_seq        <= '0;
                r_csum       <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_sum        <= n_sum;
                r_pending    <= n_pending;
                r_type       <= n_type;
                r_code       <= n_code;
                r_id         <= n_id;
                r_seq        <= n_seq;
                r_csum       <= n_csum;
            end
        end
    end

    `IEP_ASSERT_NEXT(a_run_clears, i_clk, i_rst_n, w_fire && r_last, r_byte_count == 16'd0)
    `IEP_ASSERT_NEXT(a_count_sticks, i_clk, i_rst_n, w_fire && !r_last && w_at_top, w_at_top)
    `IEP_ASSERT_NEXT(a_held_beat_kept, i_clk, i_rst_n, o_in_stall,
                     r_in_valid && $stable(r_byte) && $stable(r_last))

endmodule

FILE: rtl/iep_out_fifo.sv
// small result queue, takes up to two results a cycle and gives one
`include "icmp_echo_parser_top_macros.svh"

module iep_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  iep_pkg::t_push   i_push,
    input  iep_pkg::t_result i_res_a,
    input  iep_pkg::t_result i_res_b,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_pop,
    output iep_pkg::t_result o_head
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    iep_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] w_wr1;
    logic [PTR_W-1:0] w_wr2;
    logic [PTR_W-1:0] w_rd1;
    logic [1:0]       w_push_n;
    logic             w_pop;

    assign w_wr1 = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
    assign w_wr2 = (w_wr1 == PTR_LAST) ? '0 : w_wr1 + PTR_W'(1);
    assign w_rd1 = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);

    assign w_push_n = {1'b0, i_push.a_valid} + {1'b0, i_push.b_valid};
    assign w_pop    = i_pop && o_valid;

    // room for two results, so a final payload byte never blocks
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr] <= i_res_a;
        end
        if (i_push.b_valid) begin
            r_mem[i_push.a_valid ? w_wr1 : r_wr] <= i_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            case (w_push_n)
                2'd1:    r_wr <= w_wr1;
                2'd2:    r_wr <= w_wr2;
                default: r_wr <= r_wr;
            endcase
            if (w_pop) begin
                r_rd <= w_rd1;
            end
            r_count <= r_count + CNT_W'(w_push_n) - CNT_W'(w_pop);
        end
    end

    `IEP_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, i_push.a_valid || i_push.b_valid, o_room)
    `IEP_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `IEP_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, w_pop && (w_push_n == 2'd0), r_count == $past(r_count) - CNT_W'(1))

endmodule

FILE: rtl/icmp_echo_parser_top.sv
// icmp echo parser: checks an icmp echo message arriving one byte a beat
//
// input channel: one byte per beat (i_byte_value), i_last_byte on the final
// byte of a message. output channel: one result per beat; result_kind 0 is a
// payload byte (every byte at offset 8 and on), result_kind 1 is the status
// result that closes the message and carries the header fields when ok.
// apb port: register 0 at address 0 is the payload length limit (reset 1472).
// path: a byte passes through the input register, then the result queue, before
// its first result can be taken.
// throughput: one byte per cycle while the result queue has room; the step for
// a byte is a single 16 bit end-around-carry add, so the input register can feed
// the result queue every cycle. a final byte inside the payload yields two
// results, which the one-result-per-beat output drains one after the other.
// reset: clears the message state and the queue, the limit returns to 1472.
// output stall: results queue up (OUT_DEPTH entries); once fewer than two
// entries are free the input byte is held and o_in_stall is raised.
module icmp_echo_parser_top #(
    parameter int OUT_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_byte_value,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_result_kind,
    output logic [7:0]                     o_payload_byte,
    output logic [2:0]                     o_status,
    output logic                           o_is_request,
    output logic [15:0]                    o_identifier,
    output logic [15:0]                    o_sequence_res,
    output logic [15:0]                    o_checksum_field,
    output logic [15:0]                    o_body_len,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iep_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic             w_room;
    logic [15:0]      w_max_body_len;
    iep_pkg::t_push   w_push;
    iep_pkg::t_result w_res_a;
    iep_pkg::t_result w_res_b;
    iep_pkg::t_result w_head;

    iep_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_max_body_len (w_max_body_len)
    );

    iep_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_byte_value   (i_byte_value),
        .i_last_byte    (i_last_byte),
        .o_in_stall     (o_in_stall),
        .i_room         (w_room),
        .i_max_body_len (w_max_body_len),
        .o_push         (w_push),
        .o_res_a        (w_res_a),
        .o_res_b        (w_res_b)
    );

    iep_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res_a (w_res_a),
        .i_res_b (w_res_b),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_pop   (!i_out_stall),
        .o_head  (w_head)
    );

    assign o_result_kind    = w_head.result_kind;
    assign o_payload_byte   = w_head.payload_byte;
    assign o_status         = w_head.status;
    assign o_is_request     = w_head.is_request;
    assign o_identifier     = w_head.identifier;
    assign o_sequence_res   = w_head.sequence_res;
    assign o_checksum_field = w_head.checksum_field;
    assign o_body_len       = w_head.body_len;

endmodule

FILE: dv/icmp_echo_parser_top_test.sv
// self-checking testbench for the icmp echo parser top level
`timescale 1ns / 100ps

module icmp_echo_parser_top_test;

    localparam int QUIET_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 220;
    localparam int ADDR_W       = iep_pkg::APB_ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MAX_PAYLOAD = ADDR_W'(4 * iep_pkg::REG_MAX_PAYLOAD);
    localparam logic [ADDR_W-1:0] ADDR_SPARE       = ADDR_W'(4);

    typedef enum int {
        FLAW_NONE,
        FLAW_SHORT,
        FLAW_TYPE,
        FLAW_CODE,
        FLAW_CSUM,
        FLAW_NOISE
    } t_flaw;

    typedef struct {
        logic [7:0]  value;
        logic        last;
        int unsigned gap;
    } t_beat;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              byte_valid = 1'b0;
    logic [7:0]        byte_value = '0;
    logic              byte_last  = 1'b0;
    logic              res_stall  = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [31:0]       pwdata     = '0;

    logic        byte_stall;
    logic        res_valid;
    logic        res_kind;
    logic [7:0]  res_byte;
    logic [2:0]  res_status;
    logic        res_req;
    logic [15:0] res_id;
    logic [15:0] res_seq;
    logic [15:0] res_csum;
    logic [15:0] res_plen;
    logic [31:0] prdata;
    logic        pready;

    t_beat            bytes_pending[$];
    iep_pkg::t_result results_due[$];

    // predicted message state and limit register
    logic [15:0] lim_payload = iep_pkg::MAX_PAYLOAD_RESET;
    logic [15:0] msg_count   = '0;
    logic [15:0] msg_sum     = '0;
    logic [7:0]  msg_hi      = '0;
    logic [7:0]  msg_type    = '0;
    logic [7:0]  msg_code    = '0;
    logic [15:0] msg_csum    = '0;
    logic [15:0] msg_id      = '0;
    logic [15:0] msg_seq     = '0;

    int unsigned n_fail      = 0;
    int unsigned n_bytes     = 0;
    int unsigned n_payload   = 0;
    int unsigned n_status    = 0;
    int unsigned status_seen[8];
    int unsigned quiet       = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned snk_mode    = 0;

    icmp_echo_parser_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (byte_valid),
        .o_in_stall      (byte_stall),
        .i_byte_value    (byte_value),
        .i_last_byte     (byte_last),
        .o_out_valid     (res_valid),
        .i_out_stall     (res_stall),
        .o_result_kind   (res_kind),
        .o_payload_byte  (res_byte),
        .o_status        (res_status),
        .o_is_request    (res_req),
        .o_identifier    (res_id),
        .o_sequence_res  (res_seq),
        .o_checksum_field(res_csum),
        .o_body_len      (res_plen),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // end-around carry add
    function automatic logic [15:0] add_ones(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // sum as the block forms it, including the pairing once the count saturates
    function automatic logic [15:0] ones_sum(ref logic [7:0] msg[$]);
        logic [15:0] pos;
        logic [15:0] acc;
        logic [7:0]  hi;
        pos = '0;
        acc = '0;
        hi  = '0;
        foreach (msg[i]) begin
            if (pos[0])
                acc = add_ones(acc, {hi, msg[i]});
            else if (i == msg.size() - 1)
                acc = add_ones(acc, {msg[i], 8'h00});
            else
                hi = msg[i];
            if (pos != iep_pkg::WORD_ALL)
                pos++;
        end
        return acc;
    endfunction

    function automatic void seal(ref logic [7:0] msg[$]);
        logic [15:0] c;
        msg[2] = 8'h00;
        msg[3] = 8'h00;
        c = ~ones_sum(msg);
        msg[2] = c[15:8];
        msg[3] = c[7:0];
    endfunction

    function automatic int unsigned draw_idle(int unsigned mode);
        case (mode)
            0: return 0;
            1: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic void queue_message(ref logic [7:0] msg[$], input int unsigned pace);
        t_beat bt;
        foreach (msg[i]) begin
            bt.value = msg[i];
            bt.last  = (i == msg.size() - 1);
            bt.gap   = draw_idle(pace);
            bytes_pending.push_back(bt);
        end
    endfunction

    // one random message, well-formed in half of the draws; returns its length
    function automatic int unsigned random_message();
        logic [7:0]  msg[$];
        int unsigned len;
        t_flaw       flaw;
        case ($urandom_range(0, 9))
            0: flaw = FLAW_SHORT;
            1: flaw = FLAW_TYPE;
            2: flaw = FLAW_CODE;
            3: flaw = FLAW_CSUM;
            4: flaw = FLAW_NOISE;
            default: flaw = FLAW_NONE;
        endcase
        if (flaw == FLAW_SHORT)
            len = $urandom_range(1, 7);
        else
            len = 8 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 56)
                                                   : $urandom_range(0, 24));
        for (int unsigned j = 0; j < len; j++)
            msg.push_back(8'($urandom_range(0, 255)));
        if (flaw != FLAW_SHORT && flaw != FLAW_NOISE) begin
            msg[0] = $urandom_range(0, 1) ? iep_pkg::TYPE_REQUEST : iep_pkg::TYPE_REPLY;
            msg[1] = 8'h00;
            if (flaw == FLAW_TYPE) begin
                while (msg[0] == iep_pkg::TYPE_REQUEST || msg[0] == iep_pkg::TYPE_REPLY)
                    msg[0] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1))
                    msg[1] = 8'($urandom_range(1, 255));
            end
            if (flaw == FLAW_CODE)
                msg[1] = 8'($urandom_range(1, 255));
            seal(msg);
            // flipping only low checksum bits can never land on the other zero
            if (flaw == FLAW_CSUM || (flaw == FLAW_CODE && $urandom_range(0, 1)))
                msg[3] = msg[3] ^ 8'($urandom_range(1, 255));
        end
        queue_message(msg, $urandom_range(0, 2));
        return len;
    endfunction

    function automatic void model_byte(logic [7:0] b, logic last);
        logic [15:0]      pos;
        logic [15:0]      plen;
        iep_pkg::t_result r;
        iep_pkg::t_status st;
        pos = msg_count;
        n_bytes++;
        if (pos < iep_pkg::HEADER_LEN) begin
            case (pos[2:0])
                3'd0:       msg_type = b;
                3'd1:       msg_code = b;
                3'd2, 3'd3: msg_csum = {msg_csum[7:0], b};
                3'd4, 3'd5: msg_id = {msg_id[7:0], b};
                default:    msg_seq = {msg_seq[7:0], b};
            endcase
        end else begin
            r = '0;
            r.result_kind  = iep_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            r.status       = iep_pkg::ST_OK;
            results_due.push_back(r);
        end
        if (pos[0])
            msg_sum = add_ones(msg_sum, {msg_hi, b});
        else if (last)
            msg_sum = add_ones(msg_sum, {b, 8'h00});
        else
            msg_hi = b;
        if (pos != iep_pkg::WORD_ALL)
            msg_count = pos + 16'd1;
        if (last) begin
            plen = '0;
            if (msg_count < iep_pkg::HEADER_LEN)
                st = iep_pkg::ST_SHORT;
            else if (msg_type != iep_pkg::TYPE_REQUEST && msg_type != iep_pkg::TYPE_REPLY)
                st = iep_pkg::ST_BAD_TYPE;
            else if (msg_code != 8'h00)
                st = iep_pkg::ST_BAD_CODE;
            else if (msg_sum != iep_pkg::WORD_ALL)
                st = iep_pkg::ST_BAD_CSUM;
            else begin
                plen = msg_count - iep_pkg::HEADER_LEN;
                st   = (plen > lim_payload) ? iep_pkg::ST_TOO_LONG : iep_pkg::ST_OK;
            end
            r = '0;
            r.result_kind = iep_pkg::KIND_STATUS;
            r.status      = st;
            if (st == iep_pkg::ST_OK) begin
                r.is_request     = (msg_type == iep_pkg::TYPE_REQUEST);
                r.identifier     = msg_id;
                r.sequence_res   = msg_seq;
                r.checksum_field = msg_csum;
                r.body_len       = plen;
            end
            results_due.push_back(r);
            msg_count = '0;
            msg_sum   = '0;
            msg_hi    = '0;
            msg_type  = '0;
            msg_code  = '0;
            msg_csum  = '0;
            msg_id    = '0;
            msg_seq   = '0;
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        if (write && addr == ADDR_MAX_PAYLOAD)
            lim_payload = data[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_limit();
        logic [31:0] got;
        apb_access(1'b0, ADDR_MAX_PAYLOAD, '0, got);
        if (got[15:0] !== lim_payload) begin
            $error("max_body_len: expected %0d, got %0d", lim_payload, got[15:0]);
            n_fail++;
        end
    endtask

    task automatic write_limit(input logic [ADDR_W-1:0] addr, input logic [15:0] value);
        logic [31:0] unused;
        apb_access(1'b1, addr, {16'h0000, value}, unused);
        check_limit();
    endtask

    task automatic wait_idle();
        while (bytes_pending.size() != 0 || byte_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // byte driver
    always @(posedge clk) begin : drive_bytes
        t_beat bt;
        if (!rst_n) begin
            byte_valid <= 1'b0;
            gap_left   <= 0;
        end else if (!byte_valid || !byte_stall) begin
            if (gap_left != 0) begin
                byte_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (bytes_pending.size() != 0) begin
                bt = bytes_pending.pop_front();
                byte_valid <= 1'b1;
                byte_value <= bt.value;
                byte_last  <= bt.last;
                gap_left   <= bt.gap;
            end else begin
                byte_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && byte_valid && !byte_stall)
            model_byte(byte_value, byte_last);
    end

    // result monitor and output stall
    always @(posedge clk) begin : watch_results
        int unsigned      hold;
        iep_pkg::t_result want;
        if (!rst_n) begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            hold = stall_left;
            if (res_valid && !res_stall) begin
                if (results_due.size() == 0) begin
                    $error("result beat with nothing expected, kind %0d", res_kind);
                    n_fail++;
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", 16'(want.result_kind), 16'(res_kind));
                    check_field("payload_byte", 16'(want.payload_byte), 16'(res_byte));
                    check_field("status", 16'(want.status), 16'(res_status));
                    check_field("is_request", 16'(want.is_request), 16'(res_req));
                    check_field("identifier", want.identifier, res_id);
                    check_field("sequence_res", want.sequence_res, res_seq);
                    check_field("checksum_field", want.checksum_field, res_csum);
                    check_field("body_len", want.body_len, res_plen);
                end
                if (res_kind == iep_pkg::KIND_STATUS) begin
                    n_status++;
                    status_seen[res_status]++;
                end else begin
                    n_payload++;
                end
                if ((n_payload + n_status) % 40 == 0)
                    snk_mode = $urandom_range(0, 2);
                hold = draw_idle(snk_mode);
            end else if (hold != 0) begin
                hold--;
            end
            res_stall  <= (hold != 0);
            stall_left <= hold;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((byte_valid && !byte_stall) || (res_valid && !res_stall)
                    || (psel && penable)) begin
                quiet <= 0;
            end else if (quiet == QUIET_LIMIT) begin
                $display("[icmp_echo_parser_top] ERROR");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin : run
        logic [7:0]  msg[$];
        logic [15:0] lims[4];
        int unsigned planned;
        lims = '{16'd0, 16'd16, 16'($urandom_range(8, 40)), 16'd65527};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        check_limit();

        // lone byte, then short taking precedence over a bad type
        msg = '{8'hFF};
        queue_message(msg, 0);
        msg = '{8'h03, 8'h00, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00};
        queue_message(msg, 1);
        // all-zero reply whose checksum word alone completes the sum
        msg = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_message(msg, 0);
        // odd length: the closing payload byte is a padded high byte
        msg = '{iep_pkg::TYPE_REQUEST, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        seal(msg);
        queue_message(msg, 2);
        wait_idle();

        foreach (lims[p]) begin
            if (p == 2)
                write_limit(ADDR_SPARE, 16'h0005);
            write_limit(ADDR_MAX_PAYLOAD, lims[p]);
            planned = 0;
            while (planned < PHASE_BYTES)
                planned += random_message();
            wait_idle();
        end

        $display("drove %0d message bytes, checked %0d payload and %0d status beats",
                 n_bytes, n_payload, n_status);
        $display("status mix: ok %0d, short %0d, type %0d, code %0d, csum %0d, long %0d",
                 status_seen[iep_pkg::ST_OK], status_seen[iep_pkg::ST_SHORT],
                 status_seen[iep_pkg::ST_BAD_TYPE], status_seen[iep_pkg::ST_BAD_CODE],
                 status_seen[iep_pkg::ST_BAD_CSUM], status_seen[iep_pkg::ST_TOO_LONG]);
        if (n_fail == 0)
            $display("[icmp_echo_parser_top] OK");
        else
            $display("[icmp_echo_parser_top] ERROR");
        $finish;
    end

endmodule
